// ----- hdl/bgs_pkg.sv -----
// Package with the shared types and constants of the bilinear grid sampler.
package bgs_pkg;

  // Request kinds.
  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLUMNS = 3'd0,
    REG_NUM_ROWS    = 3'd1,
    REG_ORIGIN_X    = 3'd2,
    REG_ORIGIN_Y    = 3'd3,
    REG_INV_CELL_X  = 3'd4,
    REG_INV_CELL_Y  = 3'd5
  } cfg_reg_e;

  // Field widths fixed by the interface.
  localparam int unsigned POS_W    = 32;
  localparam int unsigned DIFF_W   = POS_W + 1;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned INV_W    = 24;
  localparam int unsigned IDX8_W   = 8;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned GRID_W   = 40;  // coordinate bits 0..39 are all that matter
  localparam int unsigned INV_LO_W = 12;
  localparam int unsigned INV_HI_W = INV_W - INV_LO_W;
  localparam int unsigned WEIGHT_W = 2 * (FRAC_W + 1) - 1;
  localparam int unsigned WSUM_SHIFT = 2 * FRAC_W;

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0] NUM_COLUMNS_RST = 9'd256;
  localparam logic [SIZE_W-1:0] NUM_ROWS_RST    = 9'd256;
  localparam logic [INV_W-1:0]  INV_CELL_RST    = 24'd65536;  // 1.0 in Q8.16

  // One whole fraction on each axis and the weight of a whole cell.
  localparam logic [FRAC_W:0]   FRAC_ONE    = 9'd256;
  localparam int unsigned       WEIGHT_ONE  = 65536;

  typedef struct packed {
    cmd_e                      command;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic [IDX8_W-1:0]         cell_col;
    logic [IDX8_W-1:0]         cell_row;
    logic signed [VALUE_W-1:0] cell_value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic [IDX8_W-1:0]         base_col;
    logic [IDX8_W-1:0]         base_row;
  } res_t;

endpackage

// ----- hdl/bgs_req_if.sv -----
// Request channel of the bilinear grid sampler: valid, ready and one request.
interface bgs_req_if;
  import bgs_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/bgs_res_if.sv -----
// Result channel of the bilinear grid sampler: valid, ready and one sample result.
interface bgs_res_if;
  import bgs_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/bilinear_grid_sampler_unit.sv -----
// Top level of the bilinear grid sampler: grid storage and the sampling pipeline.
//
// Usage:
//   req_i carries requests. A write request stores cell_value at
//   (cell_col, cell_row) and returns nothing; a sample request returns one
//   result on res_o with the interpolated value and the lower neighbor
//   column and row. Results come out in request order. The user must
//   write the configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) only
//   while the block is idle (not enforced); unknown indexes are ignored.
// Timing:
//   One request is taken every cycle unless the stages are stalled:
//   the grid is held in four copies, one per neighbor, each with its
//   own read port, so all four neighbors are read together. Writes go
//   into all four copies at the read stage, so a sample always sees
//   every write accepted before it.
// Reset and stall:
//   Reset empties the pipeline and loads the register defaults; the grid
//   content is unknown until written. When res_o is stalled, the stages
//   keep filling until every stage holds a request; a stage that carries
//   a write request is freed as soon as its write is done.
module bilinear_grid_sampler_unit #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned CELL_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  bgs_req_if.sink                             req_i,
  bgs_res_if.source                           res_o,
  input  logic                                cfg_we_i,
  input  logic [bgs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bgs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import bgs_pkg::*;

  localparam int unsigned MEM_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned NUM_BANKS = 4;
  localparam int unsigned PROD_W    = CELL_BITS + WEIGHT_W + 1;
  localparam int unsigned SUM_W     = PROD_W + 2;

  // Row-major cell address.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col);
  endfunction

  // Configuration registers.
  logic [SIZE_W-1:0]        num_cols_q;
  logic [SIZE_W-1:0]        num_rows_q;
  logic signed [POS_W-1:0]  origin_x_q;
  logic signed [POS_W-1:0]  origin_y_q;
  logic [INV_W-1:0]         inv_x_q;
  logic [INV_W-1:0]         inv_y_q;

  // Stage valids and stage ready chain.
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // Stage 1: origin removed.
  cmd_e                       s1_cmd_q;
  logic signed [DIFF_W-1:0]   s1_dx_q, s1_dy_q;
  logic [IDX8_W-1:0]          s1_col_q, s1_row_q;
  logic signed [CELL_BITS-1:0] s1_val_q;

  // Stage 2: partial products of the scaling.
  cmd_e                       s2_cmd_q;
  logic [GRID_W-1:0]          s2_plo_x_q, s2_plo_y_q;
  logic [GRID_W-INV_LO_W-1:0] s2_phi_x_q, s2_phi_y_q;
  logic [IDX8_W-1:0]          s2_col_q, s2_row_q;
  logic signed [CELL_BITS-1:0] s2_val_q;

  // Stage 3: neighbor addresses and fractions.
  cmd_e                       s3_cmd_q;
  logic                       s3_wr_ok_q;
  logic [ADDR_W-1:0]          s3_addr_q [NUM_BANKS];
  logic [FRAC_W-1:0]          s3_fx_q, s3_fy_q;
  logic [IDX8_W-1:0]          s3_bcol_q, s3_brow_q;
  logic signed [CELL_BITS-1:0] s3_val_q;

  // Stage 4: cell values and weights.
  logic signed [CELL_BITS-1:0] rd_q [NUM_BANKS];
  logic [WEIGHT_W-1:0]        s4_w_q [NUM_BANKS];
  logic [IDX8_W-1:0]          s4_bcol_q, s4_brow_q;

  // Stage 5: weighted cells.
  logic signed [PROD_W-1:0]   s5_p_q [NUM_BANKS];
  logic [IDX8_W-1:0]          s5_bcol_q, s5_brow_q;

  // Stage 6: output register.
  res_t                       s6_res_q;

  assign rdy6 = !s6_v_q || res_o.ready;
  assign rdy5 = !s5_v_q || rdy6;
  assign rdy4 = !s4_v_q || rdy5;
  assign rdy3 = !s3_v_q || rdy4;
  assign rdy2 = !s2_v_q || rdy3;
  assign rdy1 = !s1_v_q || rdy2;

  assign req_i.ready = rdy1;
  assign res_o.valid = s6_v_q;
  assign res_o.data  = s6_res_q;

  // Stage 1 datapath: subtract the origin, widen the cell value.
  logic signed [DIFF_W-1:0] dx_d, dy_d;
  logic signed [POS_W-1:0]  val32_d;

  assign dx_d    = DIFF_W'(req_i.data.pos_x) - DIFF_W'(origin_x_q);
  assign dy_d    = DIFF_W'(req_i.data.pos_y) - DIFF_W'(origin_y_q);
  assign val32_d = POS_W'(req_i.data.cell_value);

  // Stage 2 datapath: the reciprocal is split in two halves to keep each
  // multiplier narrow; only coordinate bits below GRID_W are kept.
  logic signed [GRID_W-1:0] plo_x_d, phi_x_d, plo_y_d, phi_y_d;

  assign plo_x_d = GRID_W'(s1_dx_q) * GRID_W'($signed({1'b0, inv_x_q[INV_LO_W-1:0]}));
  assign phi_x_d = GRID_W'(s1_dx_q) * GRID_W'($signed({1'b0, inv_x_q[INV_W-1:INV_LO_W]}));
  assign plo_y_d = GRID_W'(s1_dy_q) * GRID_W'($signed({1'b0, inv_y_q[INV_LO_W-1:0]}));
  assign phi_y_d = GRID_W'(s1_dy_q) * GRID_W'($signed({1'b0, inv_y_q[INV_W-1:INV_LO_W]}));

  // Stage 3 datapath: full coordinate, floor part, neighbor wrap to zero.
  logic [GRID_W-1:0]  gx_d, gy_d;
  logic [COORD_W-1:0] x1_d, x2_d, y1_d, y2_d;
  logic [COORD_W-1:0] x1w_d, x2w_d, y1w_d, y2w_d;
  logic [COORD_W-1:0] ncol_d, nrow_d;
  logic               wr_ok_d;
  logic [ADDR_W-1:0]  addr_d [NUM_BANKS];

  assign gx_d = s2_plo_x_q + {s2_phi_x_q, INV_LO_W'(0)};
  assign gy_d = s2_plo_y_q + {s2_phi_y_q, INV_LO_W'(0)};
  assign x1_d = gx_d[GRID_W-1 -: COORD_W];
  assign y1_d = gy_d[GRID_W-1 -: COORD_W];
  assign x2_d = x1_d + COORD_W'(1);
  assign y2_d = y1_d + COORD_W'(1);

  // Sizes above the maximum act as the maximum.
  assign ncol_d = (COORD_W'(num_cols_q) > COORD_W'(MAX_COLUMNS)) ?
                  COORD_W'(MAX_COLUMNS) : COORD_W'(num_cols_q);
  assign nrow_d = (COORD_W'(num_rows_q) > COORD_W'(MAX_ROWS)) ?
                  COORD_W'(MAX_ROWS) : COORD_W'(num_rows_q);

  assign x1w_d = (x1_d >= ncol_d) ? '0 : x1_d;
  assign x2w_d = (x2_d >= ncol_d) ? '0 : x2_d;
  assign y1w_d = (y1_d >= nrow_d) ? '0 : y1_d;
  assign y2w_d = (y2_d >= nrow_d) ? '0 : y2_d;

  // A write outside the physical grid is dropped.
  assign wr_ok_d = (COORD_W'(s2_col_q) < COORD_W'(MAX_COLUMNS)) &&
                   (COORD_W'(s2_row_q) < COORD_W'(MAX_ROWS));

  // Bank order: (x1,y1), (x2,y1), (x1,y2), (x2,y2); writes use one address.
  always_comb begin
    if (s2_cmd_q == CMD_SAMPLE) begin
      addr_d[0] = cell_addr(y1w_d, x1w_d);
      addr_d[1] = cell_addr(y1w_d, x2w_d);
      addr_d[2] = cell_addr(y2w_d, x1w_d);
      addr_d[3] = cell_addr(y2w_d, x2w_d);
    end else begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        addr_d[b] = cell_addr(COORD_W'(s2_row_q), COORD_W'(s2_col_q));
      end
    end
  end

  // Stage 4 datapath: the four weights, summing to one whole cell.
  logic [FRAC_W:0] fx_d, fy_d, nfx_d, nfy_d;
  logic [WEIGHT_W-1:0] w_d [NUM_BANKS];

  assign fx_d  = {1'b0, s3_fx_q};
  assign fy_d  = {1'b0, s3_fy_q};
  assign nfx_d = FRAC_ONE - fx_d;
  assign nfy_d = FRAC_ONE - fy_d;
  assign w_d[0] = WEIGHT_W'(nfx_d) * WEIGHT_W'(nfy_d);
  assign w_d[1] = WEIGHT_W'(fx_d) * WEIGHT_W'(nfy_d);
  assign w_d[2] = WEIGHT_W'(nfx_d) * WEIGHT_W'(fy_d);
  assign w_d[3] = WEIGHT_W'(fx_d) * WEIGHT_W'(fy_d);

  // Grid storage: four copies written together, each read at its neighbor.
  logic mem_en;
  logic mem_wr;

  assign mem_en = rdy4 && s3_v_q;
  assign mem_wr = mem_en && (s3_cmd_q == CMD_WRITE) && s3_wr_ok_q;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [CELL_BITS-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk_i) begin
      if (mem_wr) begin
        mem[s3_addr_q[b]] <= s3_val_q;
      end
      if (mem_en) begin
        rd_q[b] <= $signed(mem[s3_addr_q[b]]);
      end
    end
  end

  // Stage 5 datapath: one multiplier per neighbor.
  logic signed [PROD_W-1:0] p_d [NUM_BANKS];

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      p_d[b] = PROD_W'(rd_q[b]) * PROD_W'($signed({1'b0, s4_w_q[b]}));
    end
  end

  // Stage 6 datapath: sum, then divide by one whole weight toward zero.
  // The weights are non-negative and sum to one, so the result always fits.
  logic signed [SUM_W-1:0] sum_d, biased_d, quot_d;

  assign sum_d = SUM_W'(s5_p_q[0]) + SUM_W'(s5_p_q[1]) +
                 SUM_W'(s5_p_q[2]) + SUM_W'(s5_p_q[3]);
  assign biased_d = sum_d[SUM_W-1] ? (sum_d + SUM_W'(WEIGHT_ONE - 1)) : sum_d;
  assign quot_d   = biased_d >>> WSUM_SHIFT;

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      s4_v_q     <= 1'b0;
      s5_v_q     <= 1'b0;
      s6_v_q     <= 1'b0;
      num_cols_q <= NUM_COLUMNS_RST;
      num_rows_q <= NUM_ROWS_RST;
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_x_q    <= INV_CELL_RST;
      inv_y_q    <= INV_CELL_RST;
    end else begin
      if (rdy1) s1_v_q <= req_i.valid;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) s3_v_q <= s2_v_q;
      if (rdy4) s4_v_q <= s3_v_q && (s3_cmd_q == CMD_SAMPLE);
      if (rdy5) s5_v_q <= s4_v_q;
      if (rdy6) s6_v_q <= s5_v_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NUM_COLUMNS: num_cols_q <= cfg_data_i[SIZE_W-1:0];
          REG_NUM_ROWS:    num_rows_q <= cfg_data_i[SIZE_W-1:0];
          REG_ORIGIN_X:    origin_x_q <= $signed(cfg_data_i[POS_W-1:0]);
          REG_ORIGIN_Y:    origin_y_q <= $signed(cfg_data_i[POS_W-1:0]);
          REG_INV_CELL_X:  inv_x_q    <= cfg_data_i[INV_W-1:0];
          REG_INV_CELL_Y:  inv_y_q    <= cfg_data_i[INV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (rdy1 && req_i.valid) begin
      s1_cmd_q <= req_i.data.command;
      s1_dx_q  <= dx_d;
      s1_dy_q  <= dy_d;
      s1_col_q <= req_i.data.cell_col;
      s1_row_q <= req_i.data.cell_row;
      s1_val_q <= val32_d[CELL_BITS-1:0];
    end
    if (rdy2 && s1_v_q) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_plo_x_q <= plo_x_d;
      s2_phi_x_q <= phi_x_d[GRID_W-INV_LO_W-1:0];
      s2_plo_y_q <= plo_y_d;
      s2_phi_y_q <= phi_y_d[GRID_W-INV_LO_W-1:0];
      s2_col_q   <= s1_col_q;
      s2_row_q   <= s1_row_q;
      s2_val_q   <= s1_val_q;
    end
    if (rdy3 && s2_v_q) begin
      s3_cmd_q   <= s2_cmd_q;
      s3_wr_ok_q <= wr_ok_d;
      s3_addr_q  <= addr_d;
      s3_fx_q    <= gx_d[GRID_W-COORD_W-1 -: FRAC_W];
      s3_fy_q    <= gy_d[GRID_W-COORD_W-1 -: FRAC_W];
      s3_bcol_q  <= x1w_d[IDX8_W-1:0];
      s3_brow_q  <= y1w_d[IDX8_W-1:0];
      s3_val_q   <= s2_val_q;
    end
    if (rdy4 && s3_v_q) begin
      s4_w_q    <= w_d;
      s4_bcol_q <= s3_bcol_q;
      s4_brow_q <= s3_brow_q;
    end
    if (rdy5 && s4_v_q) begin
      s5_p_q    <= p_d;
      s5_bcol_q <= s4_bcol_q;
      s5_brow_q <= s4_brow_q;
    end
    if (rdy6 && s5_v_q) begin
      s6_res_q.sample_value <= quot_d[VALUE_W-1:0];
      s6_res_q.base_col     <= s5_bcol_q;
      s6_res_q.base_row     <= s5_brow_q;
    end
  end

`ifndef NO_ASSERTIONS
  // The four neighbor weights always add up to one whole cell.
  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> ((32'(s4_w_q[0]) + 32'(s4_w_q[1]) + 32'(s4_w_q[2]) + 32'(s4_w_q[3]))
                == 32'(WEIGHT_ONE)))
    else $error("bilinear weights do not sum to one");

  // The first and last wrapped sample addresses stay inside the grid storage.
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && (s3_cmd_q == CMD_SAMPLE)) |->
      ((32'(s3_addr_q[0]) < 32'(MEM_DEPTH)) && (32'(s3_addr_q[3]) < 32'(MEM_DEPTH))))
    else $error("sample address outside the grid");

  // A sample leaving the address stage reaches the read-data stage.
  a_sample_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && (s3_cmd_q == CMD_SAMPLE) && rdy4) |=> s4_v_q)
    else $error("sample request lost at the grid read");
`endif

endmodule
